// ----- hdl/srd_pkg.sv -----
// Shared types and codes of the status record deframer.
`timescale 1ns / 1ps

package srd_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STATUS_COMMAND = 1'b0,
        CFG_POWER_TARGET   = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        PH_SERIAL  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_EXTLEN  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        EV_OK             = 3'd0,
        EV_UNKNOWN_TARGET = 3'd1,
        EV_SHORT_STATUS   = 3'd2,
        EV_UNKNOWN_CMD    = 3'd3,
        EV_SHORT_PACKET   = 3'd4
    } t_event;

    localparam logic [3:0] EXT_LEN_CODE   = 4'hf;
    localparam logic [7:0] MIN_STATUS_LEN = 8'd4;
    localparam logic [2:0] INDEX_SAT      = 3'd4;
    localparam logic [2:0] INDEX_FOURTH   = 3'd3;

endpackage

// ----- hdl/srd_in_if.sv -----
// Input byte channel of the status record deframer.
`timescale 1ns / 1ps

interface srd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;

    modport source (output valid, output data_byte, output first_of_packet,
                    output last_of_packet, input ready);
    modport sink (input valid, input data_byte, input first_of_packet,
                  input last_of_packet, output ready);
endinterface

// ----- hdl/srd_out_if.sv -----
// Result channel of the status record deframer.
`timescale 1ns / 1ps

interface srd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [3:0] command;
    logic [7:0] record_length;
    logic [7:0] target_seen;
    logic [7:0] power_state;

    modport source (output valid, output event_res, output command,
                    output record_length, output target_seen, output power_state,
                    input ready);
    modport sink (input valid, input event_res, input command,
                  input record_length, input target_seen, input power_state,
                  output ready);
endinterface

// ----- hdl/status_record_deframer_unit.sv -----
// Top level of the status record deframer: byte parser and result register.
`timescale 1ns / 1ps

// The deframer takes one packet byte per clock cycle and answers in the
// cycle after the byte is accepted, with at most one result transaction per
// byte. All parsing is a small state update between the byte channel and a
// single output register; a new byte is accepted whenever that register is
// empty or is being emptied in the same cycle, so a sink that always takes
// results sees a sustained rate of one byte per cycle. Configuration writes
// take effect on the next cycle and must only be issued while no byte is
// in flight.
module status_record_deframer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srd_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [srd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    srd_in_if.sink                            i_in,
    srd_out_if.source                         o_out
);
    import srd_pkg::*;

    logic [3:0] r_status_command;
    logic [7:0] r_power_target;

    t_phase     r_phase,     n_phase;
    logic [7:0] r_remaining, n_remaining;
    logic [3:0] r_cmd,       n_cmd;
    logic [7:0] r_len,       n_len;
    logic [2:0] r_idx,       n_idx;
    logic [7:0] r_first,     n_first;
    logic [7:0] r_fourth,    n_fourth;
    logic [7:0] r_power,     n_power;

    logic       r_out_valid;
    t_event     r_ev,        n_ev;
    logic [3:0] r_out_cmd;
    logic [7:0] r_out_len;
    logic [7:0] r_out_target;
    logic [7:0] r_out_power;

    logic       accept;
    logic       emit;
    logic       hdr_done;
    logic       do_finish;
    logic [7:0] rem_dec;
    t_phase     after;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign after      = i_in.last_of_packet ? PH_SERIAL : PH_HEADER;
    assign rem_dec    = (r_remaining != 8'd0) ? (r_remaining - 8'd1) : r_remaining;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_idx       = r_idx;
        n_first     = r_first;
        n_fourth    = r_fourth;
        n_power     = r_power;
        n_ev        = EV_OK;
        emit        = 1'b0;
        hdr_done    = 1'b0;
        do_finish   = 1'b0;

        if (accept) begin
            if (i_in.first_of_packet || r_phase == PH_SERIAL) begin
                n_phase = after;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_cmd    = i_in.data_byte[7:4];
                        n_len    = {4'd0, i_in.data_byte[3:0]};
                        n_idx    = 3'd0;
                        n_first  = 8'd0;
                        n_fourth = 8'd0;
                        if (i_in.data_byte[3:0] == EXT_LEN_CODE) begin
                            if (i_in.last_of_packet) begin
                                n_phase = PH_SERIAL;
                                emit    = 1'b1;
                                n_ev    = EV_SHORT_PACKET;
                            end else begin
                                n_phase = PH_EXTLEN;
                            end
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                    PH_EXTLEN: begin
                        n_len    = i_in.data_byte;
                        hdr_done = 1'b1;
                    end
                    PH_PAYLOAD: begin
                        if (r_idx == 3'd0) begin
                            n_first = i_in.data_byte;
                        end else if (r_idx == INDEX_FOURTH) begin
                            n_fourth = i_in.data_byte;
                        end
                        if (r_idx < INDEX_SAT) begin
                            n_idx = r_idx + 3'd1;
                        end
                        n_remaining = rem_dec;
                        if (rem_dec == 8'd0) begin
                            do_finish = 1'b1;
                        end else if (i_in.last_of_packet) begin
                            n_phase = PH_SERIAL;
                            emit    = 1'b1;
                            n_ev    = EV_SHORT_PACKET;
                        end
                    end
                    default: begin
                        n_phase = PH_SERIAL;
                    end
                endcase

                if (hdr_done) begin
                    if (n_len == 8'd0) begin
                        do_finish = 1'b1;
                    end else if (i_in.last_of_packet) begin
                        n_phase = PH_SERIAL;
                        emit    = 1'b1;
                        n_ev    = EV_SHORT_PACKET;
                    end else begin
                        n_remaining = n_len;
                        n_phase     = PH_PAYLOAD;
                    end
                end

                if (do_finish) begin
                    n_phase = after;
                    emit    = 1'b1;
                    if (n_cmd != r_status_command) begin
                        n_ev = EV_UNKNOWN_CMD;
                    end else if (n_len < MIN_STATUS_LEN) begin
                        n_ev = EV_SHORT_STATUS;
                    end else if (n_first != r_power_target) begin
                        n_ev = EV_UNKNOWN_TARGET;
                    end else begin
                        n_ev    = EV_OK;
                        n_power = n_fourth;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_command <= 4'd0;
            r_power_target   <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATUS_COMMAND: r_status_command <= i_cfg_data[3:0];
                CFG_POWER_TARGET:   r_power_target   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SERIAL;
            r_remaining <= 8'd0;
            r_cmd       <= 4'd0;
            r_len       <= 8'd0;
            r_idx       <= 3'd0;
            r_first     <= 8'd0;
            r_fourth    <= 8'd0;
            r_power     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_cmd       <= n_cmd;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_first     <= n_first;
            r_fourth    <= n_fourth;
            r_power     <= n_power;
            if (accept) begin
                r_out_valid <= emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_ev         <= n_ev;
            r_out_cmd    <= n_cmd;
            r_out_len    <= n_len;
            r_out_target <= (n_idx != 3'd0) ? n_first : 8'd0;
            r_out_power  <= n_power;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_res     = r_ev;
    assign o_out.command       = r_out_cmd;
    assign o_out.record_length = r_out_len;
    assign o_out.target_seen   = r_out_target;
    assign o_out.power_state   = r_out_power;

endmodule

// ----- verif/status_record_deframer_unit_tb.sv -----
// Self-checking testbench for the status record deframer: packet stimulus, prediction, checks.
`timescale 1ns / 1ps

module status_record_deframer_unit_tb;
    import srd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 300;

    typedef struct {
        t_event     ev;
        logic [3:0] command;
        logic [7:0] length;
        logic [7:0] target;
        logic [7:0] power;
    } t_record;

    class record_scoreboard;
        logic [3:0] status_cmd;
        logic [7:0] power_tgt;
        t_phase     phase;
        logic [7:0] remaining;
        logic [3:0] cur_cmd;
        logic [7:0] cur_len;
        logic [2:0] pay_idx;
        logic [7:0] first_pay;
        logic [7:0] fourth_pay;
        logic [7:0] power_reg;
        t_record    expected[$];
        int         errors;

        function new();
            status_cmd = '0;
            power_tgt  = '0;
            phase      = PH_SERIAL;
            remaining  = '0;
            cur_cmd    = '0;
            cur_len    = '0;
            pay_idx    = '0;
            first_pay  = '0;
            fourth_pay = '0;
            power_reg  = '0;
            errors     = 0;
        endfunction

        function t_event close_record();
            if (cur_cmd != status_cmd) return EV_UNKNOWN_CMD;
            if (cur_len < MIN_STATUS_LEN) return EV_SHORT_STATUS;
            if (first_pay != power_tgt) return EV_UNKNOWN_TARGET;
            power_reg = fourth_pay;
            return EV_OK;
        endfunction

        function void post(t_event ev);
            t_record r;
            r.ev      = ev;
            r.command = cur_cmd;
            r.length  = cur_len;
            r.target  = (pay_idx != 0) ? first_pay : 8'h00;
            r.power   = power_reg;
            expected.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, bit is_first, bit is_last);
            t_phase next_phase;
            next_phase = is_last ? PH_SERIAL : PH_HEADER;
            if (is_first || phase == PH_SERIAL) begin
                phase = next_phase;
                return;
            end
            case (phase)
                PH_HEADER: begin
                    cur_cmd    = b[7:4];
                    cur_len    = {4'h0, b[3:0]};
                    pay_idx    = '0;
                    first_pay  = '0;
                    fourth_pay = '0;
                    if (b[3:0] == EXT_LEN_CODE) begin
                        if (is_last) begin
                            phase = PH_SERIAL;
                            post(EV_SHORT_PACKET);
                        end else begin
                            phase = PH_EXTLEN;
                        end
                        return;
                    end
                end
                PH_EXTLEN: begin
                    cur_len = b;
                end
                default: begin
                    if (pay_idx == 0) first_pay = b;
                    else if (pay_idx == INDEX_FOURTH) fourth_pay = b;
                    if (pay_idx < INDEX_SAT) pay_idx++;
                    if (remaining > 0) remaining--;
                    if (remaining == 0) begin
                        phase = next_phase;
                        post(close_record());
                    end else if (is_last) begin
                        phase = PH_SERIAL;
                        post(EV_SHORT_PACKET);
                    end
                    return;
                end
            endcase
            if (cur_len == 0) begin
                phase = next_phase;
                post(close_record());
            end else if (is_last) begin
                phase = PH_SERIAL;
                post(EV_SHORT_PACKET);
            end else begin
                remaining = cur_len;
                phase     = PH_PAYLOAD;
            end
        endfunction

        function void check_record(t_record got);
            t_record want;
            if (expected.size() == 0) begin
                $error("unexpected result transaction: event_res %0d command %0d",
                       got.ev, got.command);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.ev !== want.ev) begin
                $error("event_res: expected %0d, actual %0d", want.ev, got.ev);
                errors++;
            end
            if (got.command !== want.command) begin
                $error("command: expected %0d, actual %0d", want.command, got.command);
                errors++;
            end
            if (got.length !== want.length) begin
                $error("record_length: expected %0d, actual %0d", want.length, got.length);
                errors++;
            end
            if (got.target !== want.target) begin
                $error("target_seen: expected %0d, actual %0d", want.target, got.target);
                errors++;
            end
            if (got.power !== want.power) begin
                $error("power_state: expected %0d, actual %0d", want.power, got.power);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    srd_in_if  in_if ();
    srd_out_if out_if ();

    status_record_deframer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    record_scoreboard rec = new();

    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_cycles    = 0;
    int         items_sent     = 0;
    int         cycle_count    = 0;
    logic [3:0] cfg_cmd;
    logic [7:0] cfg_target;

    localparam logic [9:0] DIRECTED [25] = '{
        {2'b10, 8'hFF}, {2'b00, 8'hA4}, {2'b00, 8'h3C}, {2'b00, 8'h11}, {2'b00, 8'h22},
        {2'b00, 8'h77}, {2'b00, 8'h00}, {2'b00, 8'hAF}, {2'b00, 8'h00}, {2'b00, 8'hA4},
        {2'b00, 8'hFF}, {2'b00, 8'h01}, {2'b00, 8'h02}, {2'b00, 8'h03}, {2'b01, 8'hAF},
        {2'b10, 8'h00}, {2'b00, 8'hF5}, {2'b00, 8'h3C}, {2'b10, 8'hD3}, {2'b00, 8'hA8},
        {2'b01, 8'h3C}, {2'b00, 8'h5A}, {2'b00, 8'hAF}, {2'b00, 8'h06}, {2'b01, 8'h3C}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_record got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.ev      = t_event'(out_if.event_res);
            got.command = out_if.command;
            got.length  = out_if.record_length;
            got.target  = out_if.target_seen;
            got.power   = out_if.power_state;
            rec.check_record(got);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit is_first, input bit is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.data_byte       <= b;
        in_if.first_of_packet <= is_first;
        in_if.last_of_packet  <= is_last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        rec.note_byte(b, is_first, is_last);
        items_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (rec.expected.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [3:0] c, input logic [7:0] t);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_STATUS_COMMAND;
        i_cfg_data  <= {4'h0, c};
        @(posedge i_clk);
        rec.status_cmd = c;
        i_cfg_index <= CFG_POWER_TARGET;
        i_cfg_data  <= t;
        @(posedge i_clk);
        rec.power_tgt = t;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [9:0] pkt[$];
        int         p;
        int         goal;
        int         nrec;
        int         len;
        int         sel;
        int         cut;
        bit         ext;
        bit         clean;
        logic [3:0] hdr_cmd;

        clean = 1'b1;
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_index           <= CFG_STATUS_COMMAND;
        i_cfg_data            <= '0;
        in_if.valid           <= 1'b0;
        in_if.data_byte       <= '0;
        in_if.first_of_packet <= 1'b0;
        in_if.last_of_packet  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_cmd    = 4'hA;
        cfg_target = 8'h3C;
        configure(cfg_cmd, cfg_target);
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][9], DIRECTED[i][8]);

        for (p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: begin
                    cfg_cmd = 4'h0; cfg_target = 8'h00;
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    cfg_cmd = 4'hF; cfg_target = 8'hFF;
                    send_idle_pct = 87; recv_stall_pct = 0;
                end
                2: begin
                    cfg_cmd = 4'($urandom); cfg_target = 8'($urandom);
                    send_idle_pct = 0; recv_stall_pct = 87;
                end
                default: begin
                    cfg_cmd = 4'($urandom); cfg_target = 8'($urandom);
                    send_idle_pct = 34; recv_stall_pct = 34;
                end
            endcase
            configure(cfg_cmd, cfg_target);
            if (p == 0) hold_cycles = 300;
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                pkt.delete();
                sel = $urandom_range(99);
                if (sel < 5) begin
                    nrec = $urandom_range(1, 6);
                    repeat (nrec) pkt.push_back(10'($urandom));
                    clean = 1'b0;
                end else begin
                    pkt.push_back({(clean && $urandom_range(9) == 0) ? 1'b0 : 1'b1, 1'b0,
                                   8'($urandom)});
                    nrec = $urandom_range(0, 4);
                    repeat (nrec) begin
                        hdr_cmd = ($urandom_range(99) < 70) ? cfg_cmd : 4'($urandom);
                        sel = $urandom_range(99);
                        ext = 1'b0;
                        if (sel < 15) len = $urandom_range(0, 3);
                        else if (sel < 70) len = $urandom_range(4, 8);
                        else if (sel < 85) len = $urandom_range(9, 14);
                        else begin
                            ext = 1'b1;
                            len = ($urandom_range(99) < 3) ? $urandom_range(200, 255)
                                                           : $urandom_range(0, 20);
                        end
                        pkt.push_back({2'b00, hdr_cmd, ext ? EXT_LEN_CODE : 4'(len)});
                        if (ext) pkt.push_back({2'b00, 8'(len)});
                        for (int i = 0; i < len; i++) begin
                            pkt.push_back({2'b00, (i == 0 && $urandom_range(99) < 75)
                                                  ? cfg_target : 8'($urandom)});
                        end
                    end
                    sel = $urandom_range(99);
                    if (sel < 10 && pkt.size() > 1) begin
                        cut = $urandom_range(1, pkt.size() - 1);
                        while (pkt.size() > cut) void'(pkt.pop_back());
                    end
                    if (sel < 92) begin
                        pkt[pkt.size() - 1][8] = 1'b1;
                        clean = 1'b1;
                    end else begin
                        clean = 1'b0;
                    end
                end
                foreach (pkt[i]) send_byte(pkt[i][7:0], pkt[i][9], pkt[i][8]);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (rec.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
